[rtl/spmq_pkg.sv]
package spmq_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int HANDLE_BITS = 16;
   localparam int PRIO_BITS   = 3;
   localparam int ADDR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   typedef logic [PRIO_BITS-1:0]   prio_type;
   typedef logic [HANDLE_BITS-1:0] handle_type;
   typedef logic [ADDR_BITS-1:0]   addr_type;
   typedef logic [COUNT_BITS-1:0]  count_type;

   typedef struct packed {
      prio_type   prio;
      handle_type handle;
   } entry_type;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_OFFER = 2'd1,
      CMD_SCAN  = 2'd2,
      CMD_DRAIN = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_PUSH_WR,
      ST_OFFER,
      ST_LIST
   } state_type;

endpackage

[rtl/stable_priority_message_queue.sv]
// channel | direction | fields
// req     | in        | command, entry_priority, entry_handle, consumer_accepts
// rsp     | out       | entry_valid, out_priority, out_handle, status, was_removed,
//         |           | last_of_run, entry_count
// one transaction is taken at a time; a push shifts one stored entry per cycle
// through the entry memory (one write, one read port); a push onto an empty queue
// writes slot 0 directly
// an offer does one memory read, a scan or drain one memory read per listed
// entry; full or empty cases are answered without a memory read
// reset is synchronous and clears the count, sequencer and output valid only
// a stall on rsp holds the output register and pauses scan and drain listing
module stable_priority_message_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_command,
   input  logic [2:0]              req_entry_priority,
   input  spmq_pkg::handle_type    req_entry_handle,
   input  logic                    req_consumer_accepts,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_entry_valid,
   output logic [2:0]              rsp_out_priority,
   output spmq_pkg::handle_type    rsp_out_handle,
   output logic [1:0]              rsp_status,
   output logic                    rsp_was_removed,
   output logic                    rsp_last_of_run,
   output logic [5:0]              rsp_entry_count
);
   import spmq_pkg::*;

   // entry memory, one write and one registered read per cycle
   entry_type mem [QUEUE_DEPTH];
   entry_type rd_data_ff;
   logic      rd_en;
   addr_type  rd_addr;
   logic      wr_en;
   addr_type  wr_addr;
   entry_type wr_data;

   state_type state_ff, state_in;
   count_type count_ff, count_in;
   addr_type  idx_ff, idx_in;     // insertion slot or listing position
   entry_type new_ff, new_in;     // entry being pushed
   logic      drain_ff, drain_in;
   logic      accept_ff, accept_in;

   logic       out_valid_ff, out_valid_in;
   logic       out_ev_ff, out_ev_in;
   entry_type  out_ent_ff, out_ent_in;
   status_type out_stat_ff, out_stat_in;
   logic       out_rem_ff, out_rem_in;
   logic       out_last_ff, out_last_in;
   count_type  out_cnt_ff, out_cnt_in;

   logic     out_free;
   logic     take;
   cmd_type  cmd;
   addr_type top_addr;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign take      = req_valid && !req_stall;
   assign cmd       = cmd_type'(req_command);
   assign top_addr  = ADDR_BITS'(count_ff - count_type'(1));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      new_in       = new_ff;
      drain_in     = drain_ff;
      accept_in    = accept_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_ev_in    = out_ev_ff;
      out_ent_in   = out_ent_ff;
      out_stat_in  = out_stat_ff;
      out_rem_in   = out_rem_ff;
      out_last_in  = out_last_ff;
      out_cnt_in   = out_cnt_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = new_ff;

      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               new_in    = '{prio: prio_type'(req_entry_priority),
                             handle: req_entry_handle};
               drain_in  = (cmd == CMD_DRAIN);
               accept_in = req_consumer_accepts;
               if (cmd == CMD_PUSH) begin
                  out_valid_in = 1'b1;
                  out_last_in  = 1'b1;
                  out_rem_in   = 1'b0;
                  if (count_ff == count_type'(QUEUE_DEPTH)) begin
                     out_ev_in   = 1'b0;
                     out_ent_in  = '0;
                     out_stat_in = STAT_FULL;
                     out_cnt_in  = count_ff;
                  end else begin
                     out_ev_in   = 1'b1;
                     out_ent_in  = new_in;
                     out_stat_in = STAT_OK;
                     out_cnt_in  = count_ff + count_type'(1);
                     count_in    = count_ff + count_type'(1);
                     if (count_ff == '0) begin
                        // empty queue, store straight into slot 0
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = new_in;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = top_addr;
                        idx_in   = ADDR_BITS'(count_ff);
                        state_in = ST_PUSH;
                     end
                  end
               end else if (count_ff == '0) begin
                  out_valid_in = 1'b1;
                  out_ev_in    = 1'b0;
                  out_ent_in   = '0;
                  out_stat_in  = STAT_EMPTY;
                  out_rem_in   = 1'b0;
                  out_last_in  = 1'b1;
                  out_cnt_in   = '0;
               end else if (cmd == CMD_OFFER) begin
                  rd_en    = 1'b1;
                  rd_addr  = top_addr;
                  state_in = ST_OFFER;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  idx_in   = '0;
                  state_in = ST_LIST;
               end
            end
         end
         ST_PUSH: begin
            // slot idx-1 is in rd_data; equal or higher priority moves up
            if (rd_data_ff.prio >= new_ff.prio) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = rd_data_ff;
               idx_in  = idx_ff - addr_type'(1);
               if (idx_ff > addr_type'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - addr_type'(2);
               end else begin
                  state_in = ST_PUSH_WR;
               end
            end else begin
               wr_en    = 1'b1;
               wr_addr  = idx_ff;
               wr_data  = new_ff;
               state_in = ST_IDLE;
            end
         end
         ST_PUSH_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = new_ff;
            state_in = ST_IDLE;
         end
         ST_OFFER: begin
            // output register is empty here, nothing loaded since accept
            if (accept_ff) begin
               count_in = count_ff - count_type'(1);
            end
            out_valid_in = 1'b1;
            out_ev_in    = 1'b1;
            out_ent_in   = rd_data_ff;
            out_stat_in  = STAT_OK;
            out_rem_in   = accept_ff;
            out_last_in  = 1'b1;
            out_cnt_in   = count_in;
            state_in     = ST_IDLE;
         end
         ST_LIST: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_ev_in    = 1'b1;
               out_ent_in   = rd_data_ff;
               out_stat_in  = STAT_OK;
               out_rem_in   = drain_ff;
               out_last_in  = (idx_ff == top_addr);
               out_cnt_in   = drain_ff ? '0 : count_ff;
               if (idx_ff == top_addr) begin
                  count_in = drain_ff ? '0 : count_ff;
                  state_in = ST_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + addr_type'(1);
                  idx_in  = idx_ff + addr_type'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff      <= idx_in;
      new_ff      <= new_in;
      drain_ff    <= drain_in;
      accept_ff   <= accept_in;
      out_ev_ff   <= out_ev_in;
      out_ent_ff  <= out_ent_in;
      out_stat_ff <= out_stat_in;
      out_rem_ff  <= out_rem_in;
      out_last_ff <= out_last_in;
      out_cnt_ff  <= out_cnt_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_entry_valid  = out_ev_ff;
   assign rsp_out_priority = out_ent_ff.prio;
   assign rsp_out_handle   = out_ent_ff.handle;
   assign rsp_status       = out_stat_ff;
   assign rsp_was_removed  = out_rem_ff;
   assign rsp_last_of_run  = out_last_ff;
   assign rsp_entry_count  = out_cnt_ff;

endmodule

[tb/tb_stable_priority_message_queue.sv]
module tb_stable_priority_message_queue;
   timeunit 1ns;
   timeprecision 1ps;
   import spmq_pkg::*;

   // bench clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #6 clock = ~clock;

   // request side
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_command = CMD_PUSH;
   logic [2:0] req_entry_priority = '0;
   handle_type req_entry_handle = '0;
   logic       req_consumer_accepts = 1'b0;

   // response side
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_entry_valid;
   logic [2:0] rsp_out_priority;
   handle_type rsp_out_handle;
   logic [1:0] rsp_status;
   logic       rsp_was_removed;
   logic       rsp_last_of_run;
   logic [5:0] rsp_entry_count;

   stable_priority_message_queue DUT (.*);

   // one predicted response transaction
   typedef struct packed {
      logic       valid;
      logic [2:0] prio;
      handle_type handle;
      logic [1:0] status;
      logic       removed;
      logic       last;
      logic [5:0] count;
   } rsp_item_type;

   // mirror of the queue contents, slot 0 lowest priority
   entry_type    mirror_slots[QUEUE_DEPTH];
   int           mirror_count = 0;
   rsp_item_type pending_rsp[$];
   int           error_count = 0;
   int           rsp_seen = 0;
   int           cycle_count = 0;
   int           sent_count = 0;
   int           push_count = 0, offer_count = 0, list_count = 0, full_count = 0;
   bit           rsp_idling_on = 1'b1;

   function automatic rsp_item_type make_rsp(logic v, logic [2:0] p, handle_type h,
                                             logic [1:0] s, logic r, logic l, int c);
      rsp_item_type x;
      x.valid = v; x.prio = p; x.handle = h; x.status = s;
      x.removed = r; x.last = l; x.count = c[5:0];
      return x;
   endfunction

   // computes the expected responses of one request transaction
   task automatic predict_queue(logic [1:0] cmd, logic [2:0] p, handle_type h, logic acc);
      int pos;
      int n;
      pos = 0;
      if (cmd == CMD_PUSH) begin
         if (mirror_count >= QUEUE_DEPTH) begin
            full_count++;
            pending_rsp.push_back(make_rsp(1'b0, 3'd0, '0, STAT_FULL, 1'b0, 1'b1,
                                           mirror_count));
         end else begin
            // stable insert: goes in front of equal priorities
            while (pos < mirror_count && mirror_slots[pos].prio < p) pos++;
            for (int i = mirror_count; i > pos; i--) mirror_slots[i] = mirror_slots[i-1];
            mirror_slots[pos].prio = p;
            mirror_slots[pos].handle = h;
            mirror_count++;
            pending_rsp.push_back(make_rsp(1'b1, p, h, STAT_OK, 1'b0, 1'b1, mirror_count));
         end
      end else if (mirror_count == 0) begin
         pending_rsp.push_back(make_rsp(1'b0, 3'd0, '0, STAT_EMPTY, 1'b0, 1'b1, 0));
      end else if (cmd == CMD_OFFER) begin
         n = mirror_count - 1;
         if (acc) mirror_count = n;
         pending_rsp.push_back(make_rsp(1'b1, mirror_slots[n].prio, mirror_slots[n].handle,
                                        STAT_OK, acc, 1'b1, mirror_count));
      end else begin
         n = mirror_count;
         if (cmd == CMD_DRAIN) mirror_count = 0;
         for (int i = 0; i < n; i++)
            pending_rsp.push_back(make_rsp(1'b1, mirror_slots[i].prio,
                                           mirror_slots[i].handle,
                                           STAT_OK, cmd == CMD_DRAIN, i == n - 1,
                                           mirror_count));
      end
   endtask

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // drives one request transaction and waits for acceptance
   task automatic send_request(logic [1:0] cmd, logic [2:0] p, handle_type h, logic acc,
                               bit idle_gaps = 1'b1);
      int g;
      g = idle_gaps ? gap_length() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_entry_priority <= p;
      req_entry_handle <= h;
      req_consumer_accepts <= acc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge: predict now, in request order
      predict_queue(cmd, p, h, acc);
      sent_count++;
      case (cmd)
         CMD_PUSH:  push_count++;
         CMD_OFFER: offer_count++;
         default:   list_count++;
      endcase
   endtask

   task automatic wait_all_responses();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // response stall pattern
   always @(posedge clock) begin
      if (rsp_idling_on) rsp_stall <= (gap_length() != 0);
      else rsp_stall <= 1'b0;
   end

   // response checker, samples at the edge
   always @(posedge clock) begin
      rsp_item_type exp_rsp;
      cycle_count++;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response transaction");
            error_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_entry_valid !== exp_rsp.valid) begin
               $error("entry_valid exp %0d got %0d", exp_rsp.valid, rsp_entry_valid);
               error_count++;
            end
            if (rsp_out_priority !== exp_rsp.prio) begin
               $error("out_priority exp %0d got %0d", exp_rsp.prio, rsp_out_priority);
               error_count++;
            end
            if (rsp_out_handle !== exp_rsp.handle) begin
               $error("out_handle exp %0h got %0h", exp_rsp.handle, rsp_out_handle);
               error_count++;
            end
            if (rsp_status !== exp_rsp.status) begin
               $error("status exp %0d got %0d", exp_rsp.status, rsp_status);
               error_count++;
            end
            if (rsp_was_removed !== exp_rsp.removed) begin
               $error("was_removed exp %0d got %0d", exp_rsp.removed, rsp_was_removed);
               error_count++;
            end
            if (rsp_last_of_run !== exp_rsp.last) begin
               $error("last_of_run exp %0d got %0d", exp_rsp.last, rsp_last_of_run);
               error_count++;
            end
            if (rsp_entry_count !== exp_rsp.count) begin
               $error("entry_count exp %0d got %0d", exp_rsp.count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > 2000000) begin
         $display("simulation failed");
         $finish;
      end
   end

   // empty queue: every non-push command reports empty
   task automatic test_empty_queue();
      send_request(CMD_OFFER, 3'd7, 16'hffff, 1'b1);
      send_request(CMD_SCAN, 3'd0, 16'h0000, 1'b0);
      send_request(CMD_DRAIN, 3'd5, 16'h1234, 1'b1);
   endtask

   // extremes of priority and handle, equal priorities
   task automatic test_ordering();
      send_request(CMD_PUSH, 3'd2, 16'h0000, 1'b1);
      send_request(CMD_PUSH, 3'd2, 16'hffff, 1'b0);
      send_request(CMD_PUSH, 3'd0, 16'h00aa, 1'b0);
      send_request(CMD_PUSH, 3'd4, 16'h5555, 1'b0);
      send_request(CMD_PUSH, 3'd7, 16'haaaa, 1'b0);
      send_request(CMD_PUSH, 3'd5, 16'h0f0f, 1'b1);
      send_request(CMD_PUSH, 3'd4, 16'h8001, 1'b0);
      send_request(CMD_SCAN, 3'd1, 16'h7777, 1'b1);
      send_request(CMD_OFFER, 3'd0, 16'h0000, 1'b0);
      send_request(CMD_OFFER, 3'd6, 16'h1111, 1'b1);
      send_request(CMD_OFFER, 3'd0, 16'h0000, 1'b1);
      send_request(CMD_DRAIN, 3'd0, 16'h0000, 1'b0);
      send_request(CMD_SCAN, 3'd0, 16'h0000, 1'b0);
   endtask

   // fill past capacity so the drop case shows, then scan, offer and drain the full queue
   task automatic test_full_queue();
      for (int i = 0; i < QUEUE_DEPTH + 2; i++)
         send_request(CMD_PUSH, 3'($urandom_range(0, 7)), handle_type'($urandom),
                      1'($urandom), 1'b0);
      send_request(CMD_SCAN, 3'd0, '0, 1'b0);
      send_request(CMD_OFFER, 3'd0, '0, 1'b0);
      send_request(CMD_DRAIN, 3'd0, '0, 1'b0);
   endtask

   // random mix, push heavy with a few list commands
   task automatic test_random_mix(int items);
      int r;
      logic [1:0] cmd;
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(0, 99);
         if (r < 60) cmd = CMD_PUSH;
         else if (r < 88) cmd = CMD_OFFER;
         else if (r < 95) cmd = CMD_SCAN;
         else cmd = CMD_DRAIN;
         // sender holds off until the queue has caught up
         if (i == items / 2) wait_all_responses();
         if (i == items / 3) rsp_idling_on = 1'b0;
         if (i == items / 3 + 20) rsp_idling_on = 1'b1;
         send_request(cmd, 3'($urandom_range(0, 7)), handle_type'($urandom),
                      1'($urandom), i % 17 != 5);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_ordering();
      test_full_queue();
      test_random_mix(117);
      wait_all_responses();
      repeat (40) @(posedge clock);
      $display("covered %0d requests: %0d push, %0d offer, %0d scan or drain",
               sent_count, push_count, offer_count, list_count);
      $display("checked %0d responses, %0d full drops", rsp_seen, full_count);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
